// ===== hdl/sts_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted table search package
// Shared widths, register and mode codes, request types and engine states.
// ----------------------------------------------------------------------------
package sts_pkg;

    // Table geometry and word sizes
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = 10;
    localparam int CNT_W       = 11;
    localparam int DATA_W      = 32;
    localparam int MODE_W      = 2;
    localparam int STRIDE_W    = 6;

    // Request queue between the front end and the search engine
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    // Configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_TABLE_SIZE  = 2'd0;
    localparam logic [1:0] REG_SEARCH_MODE = 2'd1;
    localparam logic [1:0] REG_JUMP_STRIDE = 2'd2;

    // Search methods
    localparam logic [MODE_W-1:0] MODE_LINEAR    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TWO_ENDED = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BINARY    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_JUMP      = 2'd3;

    // Register reset values
    localparam logic [CNT_W-1:0]    TABLE_SIZE_RST  = '0;
    localparam logic [MODE_W-1:0]   SEARCH_MODE_RST = MODE_BINARY;
    localparam logic [STRIDE_W-1:0] JUMP_STRIDE_RST = 6'd1;

    // Input request as seen on the port
    typedef struct packed {
        logic                     func;
        logic [ADDR_W-1:0]        entry_index;
        logic signed [DATA_W-1:0] entry_value;
        logic signed [DATA_W-1:0] search_key;
    } in_t;

    // Result as seen on the port
    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] found_index;
    } out_t;

    // Request kind after classification
    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SEARCH = 1'b1
    } op_t;

    // Classified request held in the queue
    typedef struct packed {
        op_t                      op;
        logic [ADDR_W-1:0]        index;
        logic signed [DATA_W-1:0] data;
    } cmd_t;

    // Search engine states
    typedef enum logic [2:0] {
        B_IDLE,
        B_LIN,
        B_TWO,
        B_BIN_RD,
        B_BIN_CMP,
        B_JMP1,
        B_JMP2,
        B_DONE
    } bst_t;

endpackage

// ===== hdl/sts_front.sv =====
// ----------------------------------------------------------------------------
// Sorted table search front end
// Accepts requests, classifies them as table writes or searches and holds
// them in a short queue for the search engine.
// ----------------------------------------------------------------------------
module sts_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  sts_pkg::in_t  in_data,
    output logic          q_vld,
    output sts_pkg::cmd_t q_cmd,
    input  logic          q_pop
);
    import sts_pkg::*;

    cmd_t              q_mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QPTR_W:0]   cnt_reg;
    logic [QPTR_W:0]   cnt_next;
    cmd_t              cls_cmd;
    logic              push;

    // Classify the incoming request; a search carries its key, a write its word
    always_comb
    begin
        cls_cmd.op    = in_data.func ? OP_SEARCH : OP_WRITE;
        cls_cmd.index = in_data.entry_index;
        cls_cmd.data  = in_data.func ? in_data.search_key : in_data.entry_value;
    end

    // Queue handshake
    assign in_ready = (cnt_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_vld    = (cnt_reg != '0);
    assign q_cmd    = q_mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !q_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= cls_cmd;
        end
    end

    // The engine never pops an empty queue.
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (cnt_reg != '0))
        else $error("queue popped while empty");

    // A request taken while the queue is full would be lost.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == (QPTR_W+1)'(QUEUE_DEPTH) && !q_pop) |=> (cnt_reg == $past(cnt_reg)))
        else $error("queue fill count changed while full and not popped");

endmodule

// ===== hdl/sts_engine.sv =====
// ----------------------------------------------------------------------------
// Sorted table search engine
// Holds the table memory, carries out writes and the four search methods with
// one registered memory read per cycle, and drives the result register.
// ----------------------------------------------------------------------------
module sts_engine (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_vld,
    input  sts_pkg::cmd_t                   q_cmd,
    output logic                            q_pop,
    input  logic [sts_pkg::CNT_W-1:0]       table_size,
    input  logic [sts_pkg::MODE_W-1:0]      search_mode,
    input  logic [sts_pkg::STRIDE_W-1:0]    jump_stride,
    output logic                            out_valid,
    input  logic                            out_ready,
    output sts_pkg::out_t                   out_data
);
    import sts_pkg::*;

    localparam logic signed [CNT_W:0] SONE = 1;

    // Table memory and its registered read data
    logic signed [DATA_W-1:0] mem [TABLE_DEPTH];
    logic signed [DATA_W-1:0] rd_data_reg;

    // Sequencer state and search registers
    bst_t                     state_reg;
    bst_t                     state_next;
    logic signed [DATA_W-1:0] key_reg;
    logic signed [DATA_W-1:0] key_next;
    logic [CNT_W-1:0]         n_reg;
    logic [CNT_W-1:0]         n_next;
    logic [STRIDE_W-1:0]      stride_reg;
    logic [STRIDE_W-1:0]      stride_next;
    logic [CNT_W-1:0]         ptr_reg;
    logic [CNT_W-1:0]         ptr_next;
    logic [CNT_W-1:0]         lim_reg;
    logic [CNT_W-1:0]         lim_next;
    logic signed [CNT_W:0]    lo_reg;
    logic signed [CNT_W:0]    lo_next;
    logic signed [CNT_W:0]    hi_reg;
    logic signed [CNT_W:0]    hi_next;
    logic                     side_reg;
    logic                     side_next;

    // Read in flight, compared in the cycle after issue
    logic                     pend_vld_reg;
    logic                     pend_vld_next;
    logic [ADDR_W-1:0]        pend_addr_reg;
    logic [ADDR_W-1:0]        pend_addr_next;
    logic                     pend_last_reg;
    logic                     pend_last_next;
    logic [CNT_W-1:0]         pend_step_reg;
    logic [CNT_W-1:0]         pend_step_next;

    // Finished search and output register
    out_t                     res_reg;
    out_t                     res_next;
    logic                     out_vld_reg;
    logic                     out_vld_next;
    out_t                     out_reg;
    out_t                     out_next;

    // Combinational helpers
    logic [CNT_W-1:0]         n_eff;
    logic [STRIDE_W-1:0]      stride_eff;
    logic [CNT_W-1:0]         stride_ext;
    logic [CNT_W-1:0]         jump_cap;
    logic [CNT_W-1:0]         jump_idx;
    logic [CNT_W:0]           bin_sum;
    logic signed [CNT_W:0]    mid_s;
    logic                     scan_state;
    logic                     iss_en;
    logic [ADDR_W-1:0]        iss_addr;
    logic                     iss_last;
    logic                     wr_en;
    logic                     out_load;
    logic                     eq;
    logic                     lt;
    logic                     fin;
    logic                     fin_found;
    logic                     to_jmp2;
    logic signed [CNT_W:0]    bin_lo;
    logic signed [CNT_W:0]    bin_hi;

    // Effective size and stride of a new search
    assign n_eff      = (table_size > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : table_size;
    assign stride_eff = (jump_stride == '0) ? STRIDE_W'(1) : jump_stride;
    assign stride_ext = CNT_W'(stride_reg);

    // Address helpers for jump and binary search
    assign jump_cap = (ptr_reg < n_reg) ? ptr_reg : n_reg;
    assign jump_idx = jump_cap - CNT_W'(1);
    assign bin_sum  = lo_reg + hi_reg;
    assign mid_s    = $signed({{(CNT_W+1-ADDR_W){1'b0}}, pend_addr_reg});

    assign scan_state = (state_reg == B_LIN) || (state_reg == B_TWO) ||
                        (state_reg == B_JMP1) || (state_reg == B_JMP2);

    // Read issue: the next table position for the current method
    always_comb
    begin
        iss_en   = 1'b0;
        iss_addr = ptr_reg[ADDR_W-1:0];
        iss_last = 1'b0;
        case (state_reg)
            B_LIN:
            begin
                iss_en   = (ptr_reg < n_reg);
                iss_last = (ptr_reg == n_reg - CNT_W'(1));
            end
            B_TWO:
            begin
                iss_en   = (hi_reg >= lo_reg);
                iss_addr = side_reg ? hi_reg[ADDR_W-1:0] : lo_reg[ADDR_W-1:0];
                iss_last = side_reg && (hi_reg <= lo_reg + SONE);
            end
            B_JMP1:
            begin
                iss_en   = ((ptr_reg - stride_ext) < n_reg);
                iss_addr = jump_idx[ADDR_W-1:0];
            end
            B_JMP2:
            begin
                iss_en   = (ptr_reg < lim_reg);
                iss_last = (ptr_reg == lim_reg - CNT_W'(1));
            end
            B_BIN_RD:
            begin
                iss_en   = 1'b1;
                iss_addr = bin_sum[ADDR_W:1];
            end
            default:
            begin
                iss_en = 1'b0;
            end
        endcase
    end

    // Compare the returned word with the key and decide how the search goes on
    always_comb
    begin
        eq        = (rd_data_reg == key_reg);
        lt        = (rd_data_reg < key_reg);
        fin       = 1'b0;
        fin_found = 1'b0;
        to_jmp2   = 1'b0;
        bin_lo    = lo_reg;
        bin_hi    = hi_reg;
        case (state_reg)
            B_LIN, B_TWO:
            begin
                if (pend_vld_reg)
                begin
                    if (eq)
                    begin
                        fin       = 1'b1;
                        fin_found = 1'b1;
                    end
                    else if (pend_last_reg)
                    begin
                        fin = 1'b1;
                    end
                end
            end
            B_JMP1:
            begin
                if (pend_vld_reg)
                begin
                    if (lt)
                    begin
                        fin = (pend_step_reg >= n_reg);
                    end
                    else
                    begin
                        to_jmp2 = 1'b1;
                    end
                end
            end
            B_JMP2:
            begin
                if (pend_vld_reg)
                begin
                    if (eq)
                    begin
                        fin       = 1'b1;
                        fin_found = 1'b1;
                    end
                    else if (!lt || pend_last_reg)
                    begin
                        fin = 1'b1;
                    end
                end
            end
            B_BIN_CMP:
            begin
                if (eq)
                begin
                    fin       = 1'b1;
                    fin_found = 1'b1;
                end
                else
                begin
                    if (lt)
                    begin
                        bin_lo = mid_s + SONE;
                    end
                    else
                    begin
                        bin_hi = mid_s - SONE;
                    end
                    fin = (bin_lo > bin_hi);
                end
            end
            default:
            begin
                fin = 1'b0;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (q_vld && (q_cmd.op == OP_SEARCH))
                begin
                    if (n_eff == '0)
                    begin
                        state_next = B_DONE;
                    end
                    else
                    begin
                        case (search_mode)
                            MODE_LINEAR:    state_next = B_LIN;
                            MODE_TWO_ENDED: state_next = B_TWO;
                            MODE_BINARY:    state_next = B_BIN_RD;
                            MODE_JUMP:      state_next = B_JMP1;
                            default:        state_next = B_BIN_RD;
                        endcase
                    end
                end
            end
            B_LIN, B_TWO, B_JMP2:
            begin
                if (fin)
                begin
                    state_next = B_DONE;
                end
            end
            B_JMP1:
            begin
                if (fin)
                begin
                    state_next = B_DONE;
                end
                else if (to_jmp2)
                begin
                    state_next = B_JMP2;
                end
            end
            B_BIN_RD:
            begin
                state_next = B_BIN_CMP;
            end
            B_BIN_CMP:
            begin
                state_next = fin ? B_DONE : B_BIN_RD;
            end
            B_DONE:
            begin
                if (!out_vld_reg || out_ready)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Datapath and handshake outputs
    always_comb
    begin
        q_pop          = 1'b0;
        wr_en          = 1'b0;
        out_load       = 1'b0;
        key_next       = key_reg;
        n_next         = n_reg;
        stride_next    = stride_reg;
        ptr_next       = ptr_reg;
        lim_next       = lim_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        side_next      = side_reg;
        res_next       = res_reg;
        pend_vld_next  = iss_en && scan_state && !fin && !to_jmp2;
        pend_addr_next = iss_en ? iss_addr : pend_addr_reg;
        pend_last_next = iss_last;
        pend_step_next = ptr_reg;
        case (state_reg)
            B_IDLE:
            begin
                q_pop = q_vld;
                wr_en = q_vld && (q_cmd.op == OP_WRITE);
                if (q_vld && (q_cmd.op == OP_SEARCH))
                begin
                    key_next    = q_cmd.data;
                    n_next      = n_eff;
                    stride_next = stride_eff;
                    ptr_next    = (search_mode == MODE_JUMP) ? CNT_W'(stride_eff) : '0;
                    lo_next     = '0;
                    hi_next     = $signed({1'b0, n_eff}) - SONE;
                    side_next   = 1'b0;
                    res_next    = '0;
                end
            end
            B_LIN, B_JMP2:
            begin
                if (iss_en)
                begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
            end
            B_TWO:
            begin
                if (iss_en)
                begin
                    side_next = !side_reg;
                    if (side_reg)
                    begin
                        lo_next = lo_reg + SONE;
                        hi_next = hi_reg - SONE;
                    end
                end
            end
            B_JMP1:
            begin
                if (to_jmp2)
                begin
                    ptr_next = pend_step_reg - stride_ext;
                    lim_next = (pend_step_reg < n_reg) ? pend_step_reg : n_reg;
                end
                else if (iss_en)
                begin
                    ptr_next = ptr_reg + stride_ext;
                end
            end
            B_BIN_CMP:
            begin
                lo_next = bin_lo;
                hi_next = bin_hi;
            end
            B_DONE:
            begin
                out_load = !out_vld_reg || out_ready;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
        if (fin)
        begin
            res_next.found       = fin_found;
            res_next.found_index = fin_found ? pend_addr_reg : '0;
        end
    end

    // Output register
    always_comb
    begin
        out_vld_next = (out_vld_reg && !out_ready) || out_load;
        out_next     = out_load ? res_reg : out_reg;
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    // Table memory: at most one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[q_cmd.index] <= q_cmd.data;
        end
        rd_data_reg <= mem[iss_addr];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Search and result payload registers
    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        n_reg         <= n_next;
        stride_reg    <= stride_next;
        ptr_reg       <= ptr_next;
        lim_reg       <= lim_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        side_reg      <= side_next;
        pend_addr_reg <= pend_addr_next;
        pend_last_reg <= pend_last_next;
        pend_step_reg <= pend_step_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
    end

    // Requests leave the queue only while the engine is idle.
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == B_IDLE))
        else $error("request popped while a search is running");

    // A binary probe always has a non-empty range inside the table.
    a_bin_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_BIN_RD) |-> (!lo_reg[CNT_W] && (lo_reg <= hi_reg) &&
                                     (hi_reg < $signed({1'b0, n_reg}))))
        else $error("binary search range out of order");

    // A result appears only when a search has finished.
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(state_reg == B_DONE))
        else $error("result loaded outside the done state");

    // Scanned positions stay below the table size in use.
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_vld_reg && (state_reg == B_LIN || state_reg == B_JMP2)) |->
            ({1'b0, pend_addr_reg} < n_reg))
        else $error("scan read beyond the table size");

    // The forward scan of a jump search stays inside its block.
    a_jump_block: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_JMP2) |-> (ptr_reg <= lim_reg))
        else $error("jump scan ran past its block");

endmodule

// ===== hdl/sorted_table_search_top.sv =====
// ----------------------------------------------------------------------------
// Sorted table search top level
// A table of 1024 signed words with linear, two-ended, binary and jump search.
// ----------------------------------------------------------------------------
// Each request is either a table write or a search. A search of
// n = min(table_size, 1024) entries returns exactly one result: a linear scan
// reads position by position from the start, a two-ended scan reads from both
// ends inward, binary search reads and then compares for each probe, and jump
// search steps by the stride and then scans forward inside the block it found.
// The single-port table memory gives one registered read per cycle; binary
// search waits for each read before the next address is known. A two-request
// queue decouples the input from the engine, and a result register lets the
// next request be taken while a result waits. An empty table answers not found.
// Table entries hold no defined value until written; there is no clearing pass
// after reset.
// ----------------------------------------------------------------------------
module sorted_table_search_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  sts_pkg::in_t                  in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output sts_pkg::out_t                 out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sts_pkg::PADDR_W-1:0]   paddr,
    input  logic [sts_pkg::PDATA_W-1:0]   pwdata,
    output logic [sts_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import sts_pkg::*;

    logic [CNT_W-1:0]    table_size_reg;
    logic [CNT_W-1:0]    table_size_next;
    logic [MODE_W-1:0]   search_mode_reg;
    logic [MODE_W-1:0]   search_mode_next;
    logic [STRIDE_W-1:0] jump_stride_reg;
    logic [STRIDE_W-1:0] jump_stride_next;
    logic                cfg_wr;
    logic [1:0]          reg_idx;
    logic                q_vld;
    cmd_t                q_cmd;
    logic                q_pop;

    // Configuration write decode
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_comb
    begin
        table_size_next  = table_size_reg;
        search_mode_next = search_mode_reg;
        jump_stride_next = jump_stride_reg;
        if (cfg_wr)
        begin
            case (reg_idx)
                REG_TABLE_SIZE:  table_size_next  = pwdata[CNT_W-1:0];
                REG_SEARCH_MODE: search_mode_next = pwdata[MODE_W-1:0];
                REG_JUMP_STRIDE: jump_stride_next = pwdata[STRIDE_W-1:0];
                default:         table_size_next  = table_size_reg;
            endcase
        end
    end

    // Configuration read back
    always_comb
    begin
        case (reg_idx)
            REG_TABLE_SIZE:  prdata = PDATA_W'(table_size_reg);
            REG_SEARCH_MODE: prdata = PDATA_W'(search_mode_reg);
            REG_JUMP_STRIDE: prdata = PDATA_W'(jump_stride_reg);
            default:         prdata = '0;
        endcase
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg  <= TABLE_SIZE_RST;
            search_mode_reg <= SEARCH_MODE_RST;
            jump_stride_reg <= JUMP_STRIDE_RST;
        end
        else
        begin
            table_size_reg  <= table_size_next;
            search_mode_reg <= search_mode_next;
            jump_stride_reg <= jump_stride_next;
        end
    end

    // Front end: request intake and queue
    sts_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_vld    (q_vld),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    // Back end: table memory and search sequencer
    sts_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_vld       (q_vld),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop),
        .table_size  (table_size_reg),
        .search_mode (search_mode_reg),
        .jump_stride (jump_stride_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule
